// ===== rtl/core/tes_pkg.sv =====
package tes_pkg;

  // Encoding class codes
  localparam logic [2:0] CLS_UTF8    = 3'd0;
  localparam logic [2:0] CLS_UTF16LE = 3'd1;
  localparam logic [2:0] CLS_UTF16BE = 3'd2;
  localparam logic [2:0] CLS_UTF32LE = 3'd3;
  localparam logic [2:0] CLS_UTF32BE = 3'd4;
  localparam logic [2:0] CLS_ASCII   = 3'd5;
  localparam logic [2:0] CLS_LATIN1  = 3'd6;

  // Mark bytes
  localparam logic [7:0] BYTE_EF = 8'hEF;
  localparam logic [7:0] BYTE_BB = 8'hBB;
  localparam logic [7:0] BYTE_BF = 8'hBF;
  localparam logic [7:0] BYTE_FF = 8'hFF;
  localparam logic [7:0] BYTE_FE = 8'hFE;
  localparam logic [7:0] BYTE_00 = 8'h00;

  // UTF-8 lead / continuation masks
  localparam logic [7:0] MASK_C0 = 8'hC0;
  localparam logic [7:0] MASK_E0 = 8'hE0;
  localparam logic [7:0] MASK_F0 = 8'hF0;
  localparam logic [7:0] MASK_F8 = 8'hF8;
  localparam logic [7:0] PAT_80  = 8'h80;
  localparam logic [7:0] PAT_C0  = 8'hC0;
  localparam logic [7:0] PAT_E0  = 8'hE0;
  localparam logic [7:0] PAT_F0  = 8'hF0;

  localparam logic [2:0] HEAD_FULL = 3'd4;

  // Running summary of one buffer
  typedef struct packed {
    logic [31:0] head;       // byte k in bits 8k+7..8k
    logic [2:0]  count;      // saturates at HEAD_FULL
    logic        ascii_only;
    logic        utf8_valid;
    logic [1:0]  pending;    // continuation bytes still expected
  } scan_t;

  localparam scan_t SCAN_RESET = '{head: 32'h0, count: 3'd0, ascii_only: 1'b1,
                                   utf8_valid: 1'b1, pending: 2'd0};

endpackage

// ===== rtl/core/tes_tracker.sv =====
module tes_tracker
  import tes_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       byte_present,
  input  logic [7:0] data_byte,
  input  logic       last_item,
  output scan_t      scan_next
);

  scan_t scan;

  always_comb begin
    scan_next = scan;
    if (byte_present) begin
      if (scan.count != HEAD_FULL) begin
        for (int k = 0; k < 4; k++) begin
          if (scan.count[1:0] == 2'(k)) scan_next.head[8*k +: 8] = data_byte;
        end
        scan_next.count = scan.count + 3'd1;
      end
      if (data_byte[7]) scan_next.ascii_only = 1'b0;
      if (scan.utf8_valid) begin
        priority if (scan.pending != 2'd0) begin
          if ((data_byte & MASK_C0) != PAT_80) begin
            scan_next.utf8_valid = 1'b0;
            scan_next.pending    = 2'd0;
          end else begin
            scan_next.pending = scan.pending - 2'd1;
          end
        end else if (!data_byte[7]) begin
          scan_next.pending = 2'd0;
        end else if ((data_byte & MASK_E0) == PAT_C0) begin
          scan_next.pending = 2'd1;
        end else if ((data_byte & MASK_F0) == PAT_E0) begin
          scan_next.pending = 2'd2;
        end else if ((data_byte & MASK_F8) == PAT_F0) begin
          scan_next.pending = 2'd3;
        end else begin
          scan_next.utf8_valid = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= SCAN_RESET;
    end else if (fire) begin
      scan <= last_item ? SCAN_RESET : scan_next;
    end
  end

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    scan.count <= HEAD_FULL) else $error("byte count past saturation");

  a_pend_valid: assert property (@(posedge clk) disable iff (rst)
    (scan.pending != 2'd0) |-> scan.utf8_valid)
    else $error("continuations pending after UTF-8 error");

  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    fire && last_item |=> scan.count == 3'd0 && scan.ascii_only && scan.utf8_valid
      && scan.pending == 2'd0 && scan.head == 32'h0)
    else $error("summary not cleared after buffer end");

endmodule

// ===== rtl/core/tes_classify.sv =====
module tes_classify
  import tes_pkg::*;
(
  input  scan_t      scan,
  output logic [2:0] encoding_class,
  output logic       bom_found
);

  logic [7:0] b0, b1, b2, b3;

  assign b0 = scan.head[7:0];
  assign b1 = scan.head[15:8];
  assign b2 = scan.head[23:16];
  assign b3 = scan.head[31:24];

  always_comb begin
    bom_found      = 1'b1;
    encoding_class = CLS_UTF8;
    priority if (scan.count == 3'd0) begin
      bom_found = 1'b0;
    end else if (scan.count >= 3'd3 && b0 == BYTE_EF && b1 == BYTE_BB && b2 == BYTE_BF) begin
      encoding_class = CLS_UTF8;
    end else if (scan.count == HEAD_FULL && b0 == BYTE_FF && b1 == BYTE_FE
                 && b2 == BYTE_00 && b3 == BYTE_00) begin
      encoding_class = CLS_UTF32LE;
    end else if (scan.count >= 3'd2 && b0 == BYTE_FF && b1 == BYTE_FE) begin
      encoding_class = CLS_UTF16LE;
    end else if (scan.count >= 3'd2 && b0 == BYTE_FE && b1 == BYTE_FF) begin
      encoding_class = CLS_UTF16BE;
    end else if (scan.count == HEAD_FULL && b0 == BYTE_00 && b1 == BYTE_00
                 && b2 == BYTE_FE && b3 == BYTE_FF) begin
      encoding_class = CLS_UTF32BE;
    end else begin
      bom_found = 1'b0;
      priority if (scan.ascii_only) begin
        encoding_class = CLS_ASCII;
      end else if (scan.utf8_valid && scan.pending == 2'd0) begin
        encoding_class = CLS_UTF8;
      end else begin
        encoding_class = CLS_LATIN1;
      end
    end
  end

endmodule

// ===== rtl/core/text_encoding_sniffer_core.sv =====
// Text encoding sniffer. Feed a buffer one byte per input transaction
// (byte_present = 1) and mark the final transaction with last_item; an
// end-only transaction (byte_present = 0, last_item = 1) closes the buffer,
// including an empty one. Each buffer yields exactly one output transaction:
// encoding_class (0 UTF-8, 1 UTF-16LE, 2 UTF-16BE, 3 UTF-32LE, 4 UTF-32BE,
// 5 ASCII, 6 Latin-1) and bom_found. A byte order mark wins, checked as
// UTF-8, UTF-32LE, UTF-16LE, UTF-16BE, UTF-32BE; otherwise all-ASCII, then
// valid UTF-8 (an unfinished sequence at the end is invalid), else Latin-1.
// Throughput is one transaction per clock while in_stall is low: the
// per-byte summary update and the classification are combinational logic
// between the input register and the result register. The end-of-buffer
// transaction passes through the input register and then loads the result
// register, raising out_valid. in_stall rises only when an end-of-buffer
// transaction waits in the input register while the previous result is
// still held by out_stall. State clears after each buffer, so buffers may
// follow each other without gaps.
module text_encoding_sniffer_core
  import tes_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       byte_present,
  input  logic [7:0] data_byte,
  input  logic       last_item,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] encoding_class,
  output logic       bom_found
);

  // Input register
  logic       s1_valid;
  logic       s1_present;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_move;
  logic       s1_fire;

  scan_t      scan_next;
  logic [2:0] cls_next;
  logic       bom_next;

  // The input register drains unless it holds a buffer end and the result
  // slot is occupied and not being taken.
  assign s1_move  = !s1_valid || !s1_last || !out_valid || !out_stall;
  assign s1_fire  = s1_valid && s1_move;
  assign in_stall = !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_move) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && in_valid) begin
      s1_present <= byte_present;
      s1_byte    <= data_byte;
      s1_last    <= last_item;
    end
  end

  tes_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .fire         (s1_fire),
    .byte_present (s1_present),
    .data_byte    (s1_byte),
    .last_item    (s1_last),
    .scan_next    (scan_next)
  );

  // Classification sees the summary including this transaction's byte
  tes_classify u_classify (
    .scan           (scan_next),
    .encoding_class (cls_next),
    .bom_found      (bom_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      encoding_class <= cls_next;
      bom_found      <= bom_next;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_last && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_bom_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && bom_found |-> encoding_class != CLS_ASCII && encoding_class != CLS_LATIN1)
    else $error("mark reported with a non-mark class");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> out_valid)
    else $error("buffer end produced no result");

endmodule

// ===== tb/tb_text_encoding_sniffer_core.sv =====
`timescale 1ns / 100ps

import tes_pkg::*;

// One expected output transaction
typedef struct {
  logic [2:0] cls;
  logic       bom;
} class_result_t;

// Scoreboard: tracks the running scan of the current buffer and holds the
// classes still owed by the block, oldest first.
class sniff_checker;
  scan_t         scan;
  class_result_t expected_classes[$];
  int            mismatches;

  function new();
    scan       = SCAN_RESET;
    mismatches = 0;
  endfunction

  function void take_text_byte(logic [7:0] b);
    int k;
    k = int'(scan.count);
    if (scan.count < HEAD_FULL) begin
      scan.head[8*k +: 8] = b;
      scan.count          = scan.count + 3'd1;
    end
    if (b > 8'd127) scan.ascii_only = 1'b0;
    if (!scan.utf8_valid) return;
    if (scan.pending != 2'd0) begin
      if ((b & MASK_C0) != PAT_80) begin
        scan.utf8_valid = 1'b0;
        scan.pending    = 2'd0;
      end else begin
        scan.pending = scan.pending - 2'd1;
      end
    end else if (b > 8'h7F) begin
      if ((b & MASK_E0) == PAT_C0) scan.pending = 2'd1;
      else if ((b & MASK_F0) == PAT_E0) scan.pending = 2'd2;
      else if ((b & MASK_F8) == PAT_F0) scan.pending = 2'd3;
      else scan.utf8_valid = 1'b0;
    end
  endfunction

  function class_result_t predict_class();
    class_result_t r;
    logic [7:0]    b0, b1, b2, b3;
    b0    = scan.head[7:0];
    b1    = scan.head[15:8];
    b2    = scan.head[23:16];
    b3    = scan.head[31:24];
    r.bom = 1'b1;
    if (scan.count == 3'd0) begin
      r.cls = CLS_UTF8;
      r.bom = 1'b0;
    end else if (scan.count >= 3'd3 && b0 == BYTE_EF && b1 == BYTE_BB && b2 == BYTE_BF) begin
      r.cls = CLS_UTF8;
    end else if (scan.count >= HEAD_FULL && b0 == BYTE_FF && b1 == BYTE_FE &&
                 b2 == BYTE_00 && b3 == BYTE_00) begin
      r.cls = CLS_UTF32LE;
    end else if (scan.count >= 3'd2 && b0 == BYTE_FF && b1 == BYTE_FE) begin
      r.cls = CLS_UTF16LE;
    end else if (scan.count >= 3'd2 && b0 == BYTE_FE && b1 == BYTE_FF) begin
      r.cls = CLS_UTF16BE;
    end else if (scan.count >= HEAD_FULL && b0 == BYTE_00 && b1 == BYTE_00 &&
                 b2 == BYTE_FE && b3 == BYTE_FF) begin
      r.cls = CLS_UTF32BE;
    end else begin
      r.bom = 1'b0;
      if (scan.ascii_only) r.cls = CLS_ASCII;
      else if (scan.utf8_valid && scan.pending == 2'd0) r.cls = CLS_UTF8;
      else r.cls = CLS_LATIN1;
    end
    return r;
  endfunction

  // Accepted input transaction
  function void note_transaction(logic present, logic [7:0] b, logic last);
    if (present) take_text_byte(b);
    if (last) begin
      expected_classes.push_back(predict_class());
      scan = SCAN_RESET;
    end
  endfunction

  // Accepted output transaction
  function void check_transaction(logic [2:0] cls, logic bom);
    class_result_t want;
    if (expected_classes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: class %0d bom %0d", cls, bom);
      return;
    end
    want = expected_classes.pop_front();
    if (cls !== want.cls || bom !== want.bom) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected class %0d bom %0d, got class %0d bom %0d",
                 want.cls, want.bom, cls, bom);
    end
  endfunction
endclass

module tb_text_encoding_sniffer_core;

  localparam int CYCLE_LIMIT      = 60000;  // several times the slowest legal run
  localparam int LONG_HOLD_CYCLES = 60;     // receiver back-pressure burst
  localparam int RANDOM_ITEMS     = 800;
  localparam int DRAIN_CYCLES     = 10;     // pipeline is two deep

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       byte_present;
  logic [7:0] data_byte;
  logic       last_item;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] encoding_class;
  logic       bom_found;

  sniff_checker tracker = new();

  logic [7:0] text_bytes[$];   // buffer being built for the next send
  bit         idle_off  = 1'b0; // tail of the run: no idling either side
  bit         calm      = 1'b0; // per-buffer stretch with no idling
  bit         long_hold = 1'b0; // request for a long receiver stall
  int         items_sent = 0;   // byte and end-only transactions, empties excluded
  int         cycle_count = 0;

  text_encoding_sniffer_core DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .byte_present  (byte_present),
    .data_byte     (data_byte),
    .last_item     (last_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .encoding_class(encoding_class),
    .bom_found     (bom_found)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Monitor: both channels sampled at the rising edge. The result is checked
  // before the input is noted; with a registered path the two never interact
  // within one edge anyway.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (!rst) begin
      if (out_valid && !out_stall)
        tracker.check_transaction(encoding_class, bom_found);
      if (in_valid && !in_stall)
        tracker.note_transaction(byte_present, data_byte, last_item);
    end
  end

  // Receiver: short random stall bursts, plus a long hold on request so the
  // block backs up and raises in_stall while the sender keeps offering.
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (!idle_off && !calm && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Offer one input transaction; called at a falling edge, returns at the
  // falling edge after acceptance. Valid is only dropped for an idle burst,
  // never lowered and raised within one step.
  task automatic send_item(input logic present, input logic [7:0] b, input logic last);
    if (!idle_off && !calm && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid     = 1'b1;
    byte_present = present;
    data_byte    = b;
    last_item    = last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Send text_bytes as one buffer. The end mark rides on the final byte or,
  // with end_only, on a separate transaction without a byte. Empty
  // transactions (no byte, no end) are sprinkled in; data there is junk.
  task automatic send_buffer(input bit end_only);
    int i;
    if (text_bytes.size() == 0) end_only = 1'b1;
    for (i = 0; i < text_bytes.size(); i++) begin
      if ($urandom_range(0, 11) == 0) send_item(1'b0, 8'($urandom), 1'b0);
      send_item(1'b1, text_bytes[i], !end_only && i == text_bytes.size() - 1);
      items_sent++;
    end
    if (end_only) begin
      send_item(1'b0, 8'($urandom), 1'b1);
      items_sent++;
    end
  endtask

  // Append one UTF-8 sequence of len bytes with only conts continuations;
  // conts < len - 1 leaves it unfinished.
  function automatic void push_utf8_seq(int len, int conts);
    case (len)
      1:       text_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
      2:       text_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
      3:       text_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
      default: text_bytes.push_back(8'($urandom_range(8'hF0, 8'hF7)));
    endcase
    repeat (conts) text_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
  endfunction

  // Random buffer: an optional (possibly partial) mark, then a body that is
  // mostly well-formed text with random content, sometimes noise, a bad byte
  // or a sequence cut off at the end.
  task automatic build_random_text();
    int mark, style, chars, i, len, cut;
    text_bytes.delete();
    mark = $urandom_range(0, 13);
    case (mark)
      0: text_bytes = '{BYTE_EF, BYTE_BB, BYTE_BF};
      1: text_bytes = '{BYTE_FF, BYTE_FE, BYTE_00, BYTE_00};
      2: text_bytes = '{BYTE_FF, BYTE_FE};
      3: text_bytes = '{BYTE_FE, BYTE_FF};
      4: text_bytes = '{BYTE_00, BYTE_00, BYTE_FE, BYTE_FF};
      5: begin
        // truncated UTF-32 BE mark
        cut        = $urandom_range(1, 3);
        text_bytes = '{BYTE_00, BYTE_00, BYTE_FE};
        while (text_bytes.size() > cut) void'(text_bytes.pop_back());
      end
      6: text_bytes = '{BYTE_FF, BYTE_FE, BYTE_00};
      7: text_bytes = '{BYTE_EF, BYTE_BB};
      default: ;
    endcase
    style = $urandom_range(0, 9);
    chars = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
    for (i = 0; i < chars; i++) begin
      case (style)
        0, 1, 2: push_utf8_seq(1, 0);
        7:       text_bytes.push_back(8'($urandom));
        8: begin
          if (i == chars / 2)
            text_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                      : 8'($urandom_range(8'hF8, 8'hFF)));
          else begin
            len = $urandom_range(1, 4);
            push_utf8_seq(len, len - 1);
          end
        end
        default: begin
          len = $urandom_range(1, 4);
          push_utf8_seq(len, len - 1);
        end
      endcase
    end
    if (style == 9) begin
      len = $urandom_range(2, 4);
      push_utf8_seq(len, $urandom_range(0, len - 2));
    end
  endtask

  initial begin : stimulus
    int  random_start;
    bit  second_hold;
    rst          = 1'b1;
    in_valid     = 1'b0;
    byte_present = 1'b0;
    data_byte    = 8'h00;
    last_item    = 1'b0;
    second_hold  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed ---
    // empty buffer: end-only transaction, data ignored
    send_item(1'b0, 8'hA5, 1'b1);
    // each recognized mark
    text_bytes = '{BYTE_EF, BYTE_BB, BYTE_BF};
    send_buffer(1'b0);
    text_bytes = '{BYTE_FF, BYTE_FE, BYTE_00, BYTE_00};
    send_buffer(1'b0);
    text_bytes = '{BYTE_FF, BYTE_FE, 8'h41};
    send_buffer(1'b0);
    text_bytes = '{BYTE_FE, BYTE_FF};
    send_buffer(1'b1);
    text_bytes = '{BYTE_00, BYTE_00, BYTE_FE, BYTE_FF};
    send_buffer(1'b0);
    // mark cut short, also an unfinished sequence
    text_bytes = '{BYTE_EF, BYTE_BB};
    send_buffer(1'b0);
    // ASCII extremes around an empty transaction
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b0, 8'hFF, 1'b0);
    send_item(1'b1, 8'h7F, 1'b1);
    // valid UTF-8 without a mark, then Latin-1
    text_bytes = '{8'hC3, 8'hA9};
    send_buffer(1'b0);
    text_bytes = '{8'h80, 8'hFF};
    send_buffer(1'b0);

    // --- random ---
    random_start = items_sent;
    long_hold    = 1'b1;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (!second_hold && items_sent - random_start > RANDOM_ITEMS / 2) begin
        long_hold   = 1'b1;
        second_hold = 1'b1;
      end
      if (items_sent - random_start > RANDOM_ITEMS * 85 / 100) idle_off = 1'b1;
      calm = ($urandom_range(0, 4) == 0);
      build_random_text();
      send_buffer($urandom_range(0, 3) == 0);
    end
    in_valid = 1'b0;

    // drain: wait until all classes are in, then keep watching for stray results
    while (tracker.expected_classes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.expected_classes.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
